[rtl/frs_pkg.sv]
package frs_pkg;

    // Widest count and history slot carried between the front and back parts.
    localparam int CNT_W_MAX  = 32;
    localparam int SLOT_W_MAX = 6;

    // Filter geometry.
    localparam int NUM_TAPS   = 17;
    localparam int TAP_CENTER = 8;
    localparam int TAP_IDX_W  = 5;

    // Signed tap position: 32-bit source index plus sign and one spare bit.
    localparam int POS_W = 34;

    // Phase step 22050/16000 in Q16 and its fractional part.
    localparam logic [16:0] PHASE_INC = 17'd90316;
    localparam logic [15:0] STEP_FRAC = 16'd24780;

    // Output count per input sample: 16000/22050, kept as a running remainder.
    localparam logic [15:0] RATE_OUT = 16'd16000;
    localparam logic [15:0] RATE_IN  = 16'd22050;

    // Q15 rounding constant, 1 << 14.
    localparam int ROUND_HALF = 16384;

    // Results per input beat.
    localparam int MAX_RES   = 10;
    localparam int RES_CNT_W = 4;

    localparam logic [23:0] LIMIT_RESET = 24'hFFFFFF;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_FILT,
        B_ROUND,
        B_INTERP,
        B_MIX
    } bk_state_t;

    // One accepted input beat, classified by the front part.
    typedef struct packed {
        logic signed [15:0]      sample;
        logic                    block_end;
        logic                    stored;
        logic [SLOT_W_MAX-1:0]   slot;
        logic [SLOT_W_MAX-1:0]   last_slot;
        logic [CNT_W_MAX-1:0]    seen;
        logic [CNT_W_MAX-1:0]    total;
        logic signed [15:0]      first_sample;
    } frs_cmd_t;

    // Symmetric 17-tap Q15 low-pass.
    function automatic logic signed [15:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
        logic [TAP_IDX_W-1:0]  fold;
        logic signed [15:0]    c;
        fold = (idx > TAP_IDX_W'(TAP_CENTER)) ? TAP_IDX_W'(2 * TAP_CENTER) - idx : idx;
        case (fold)
            5'd0:    c = -16'sd68;
            5'd1:    c = 16'sd167;
            5'd2:    c = -16'sd95;
            5'd3:    c = -16'sd563;
            5'd4:    c = 16'sd1323;
            5'd5:    c = -16'sd319;
            5'd6:    c = -16'sd3705;
            5'd7:    c = 16'sd8932;
            5'd8:    c = 16'sd21424;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/frs_ram.sv]
module frs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/frs_front.sv]
module frs_front #(
    parameter int HISTORY_DEPTH = 32,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic signed [15:0] sample_in,
    input  logic               block_end,
    input  logic               q_full,
    output logic               cmd_push,
    output frs_pkg::frs_cmd_t  cmd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import frs_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] SEEN_SAT = '1;
    localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);

    logic [COUNT_WIDTH-1:0] seen_reg;
    logic [COUNT_WIDTH-1:0] avail_reg;
    logic [14:0]            rem_reg;
    logic [AW-1:0]          slot_reg;
    logic [AW-1:0]          last_slot_reg;
    logic signed [15:0]     first_reg;
    logic [23:0]            limit_reg;

    logic                   stored;
    logic [COUNT_WIDTH-1:0] seen_next;
    logic [COUNT_WIDTH-1:0] avail_next;
    logic [14:0]            rem_next;
    logic [AW-1:0]          slot_next;
    logic [AW-1:0]          last_slot_next;
    logic signed [15:0]     first_next;
    logic [15:0]            rem_sum;
    logic [15:0]            rem_sub;
    logic                   rem_wrap;
    logic [CNT_W_MAX-1:0]   avail_ext;
    logic [CNT_W_MAX-1:0]   limit_ext;

    assign cmd_push  = push && !q_full;
    assign cfg_ready = 1'b1;

    // Counters advance only while the sample count is below saturation.
    always_comb
    begin
        stored         = (seen_reg != SEEN_SAT);
        seen_next      = seen_reg + COUNT_WIDTH'(stored);
        rem_sum        = {1'b0, rem_reg} + RATE_OUT;
        rem_sub        = rem_sum - RATE_IN;
        rem_wrap       = (rem_sum >= RATE_IN);
        rem_next       = stored ? (rem_wrap ? rem_sub[14:0] : rem_sum[14:0]) : rem_reg;
        avail_next     = avail_reg + COUNT_WIDTH'(stored && rem_wrap);
        slot_next      = stored ? ((slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1)
                                : slot_reg;
        last_slot_next = stored ? slot_reg : last_slot_reg;
        first_next     = (seen_reg == '0) ? sample_in : first_reg;
        avail_ext      = CNT_W_MAX'(avail_next);
        limit_ext      = CNT_W_MAX'(limit_reg);

        cmd.sample       = sample_in;
        cmd.block_end    = block_end;
        cmd.stored       = stored;
        cmd.slot         = SLOT_W_MAX'(slot_reg);
        cmd.last_slot    = SLOT_W_MAX'(last_slot_next);
        cmd.seen         = CNT_W_MAX'(seen_next);
        cmd.total        = (avail_ext > limit_ext) ? limit_ext : avail_ext;
        cmd.first_sample = first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            avail_reg     <= '0;
            rem_reg       <= '0;
            slot_reg      <= '0;
            last_slot_reg <= '0;
            first_reg     <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            if (cmd_push)
            begin
                if (block_end)
                begin
                    seen_reg      <= '0;
                    avail_reg     <= '0;
                    rem_reg       <= '0;
                    slot_reg      <= '0;
                    last_slot_reg <= '0;
                    first_reg     <= '0;
                end
                else
                begin
                    seen_reg      <= seen_next;
                    avail_reg     <= avail_next;
                    rem_reg       <= rem_next;
                    slot_reg      <= slot_next;
                    last_slot_reg <= last_slot_next;
                    first_reg     <= first_next;
                end
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/frs_cmd_queue.sv]
module frs_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  frs_pkg::frs_cmd_t q_din,
    output logic              q_full,
    input  logic              q_pop,
    output frs_pkg::frs_cmd_t q_dout,
    output logic              q_empty
);
    import frs_pkg::*;

    frs_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign q_dout  = entry_reg[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/frs_back.sv]
module frs_back #(
    parameter int HISTORY_DEPTH = 32,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  frs_pkg::frs_cmd_t  q_dout,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample_out,
    output logic               run_last,
    output logic               block_done
);
    import frs_pkg::*;

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int ACC_W = 36;
    localparam int MUL_W = 18;
    localparam int MIX_W = 20;
    localparam logic [AW-1:0] ADDR_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);

    bk_state_t state_reg;
    bk_state_t state_next;

    frs_cmd_t               cmd_reg;
    logic [COUNT_WIDTH-1:0] done_reg;
    logic [47:0]            phase_reg;
    logic [AW-1:0]          smod_reg;
    logic [RES_CNT_W-1:0]   n_reg;
    logic                   pass_reg;

    logic [TAP_IDX_W-1:0]   iss_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [AW-1:0]          addr_reg;
    logic                   v1_reg;
    logic [TAP_IDX_W-1:0]   t1_reg;
    logic                   first1_reg;
    logic                   v2_reg;
    logic                   last2_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]     a_reg;
    logic signed [15:0]     b_reg;

    logic                   hold_valid_reg;
    logic signed [15:0]     hold_reg;
    logic                   out_valid_reg;
    logic signed [15:0]     out_sample_reg;
    logic                   out_last_reg;
    logic                   out_done_reg;

    // Control strobes from the sequencer.
    logic emit;
    logic init_a;
    logic init_b;
    logic ld_a;
    logic ld_b;
    logic ld_b_dup;
    logic hold_ld;
    logic blk_clr;
    logic flt_issue;

    // Datapath.
    logic [31:0]             src;
    logic [15:0]             frac;
    logic [COUNT_WIDTH-1:0]  seen_c;
    logic [COUNT_WIDTH-1:0]  total_c;
    logic [AW-1:0]           last_slot_c;
    logic [32:0]             src_ext;
    logic [32:0]             seen_ext;
    logic                    more;
    logic                    need_b;
    logic                    out_free;
    logic                    flt_done;
    logic                    pos_neg;
    logic                    pos_past;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           addr_inc;
    logic [15:0]             ram_rdata;
    logic signed [15:0]      op_smp;
    logic signed [16:0]      diff;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_q;
    logic signed [15:0]      flt_val;
    logic signed [MIX_W-1:0] mix;
    logic signed [15:0]      mix_val;
    logic [16:0]             frac_sum;
    logic [AW:0]             smod_sum;
    logic [AW-1:0]           smod_next;
    logic signed [POS_W-1:0] pos_a;
    logic signed [POS_W-1:0] pos_b;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767))
        begin
            r = 16'sh7FFF;
        end
        else if (v < -ACC_W'(32768))
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Ring slot k places behind x.
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] x,
                                                input logic [3:0] k);
        logic [AW:0] s;
        s = {1'b0, x} + DEPTH_EXT - (AW + 1)'(k);
        if (s >= DEPTH_EXT)
        begin
            s = s - DEPTH_EXT;
        end
        return s[AW-1:0];
    endfunction

    frs_ram #(
        .WIDTH (16),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (q_pop && q_dout.stored),
        .waddr (q_dout.slot[AW-1:0]),
        .wdata (q_dout.sample),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        src         = phase_reg[47:16];
        frac        = phase_reg[15:0];
        seen_c      = cmd_reg.seen[COUNT_WIDTH-1:0];
        total_c     = cmd_reg.total[COUNT_WIDTH-1:0];
        last_slot_c = cmd_reg.last_slot[AW-1:0];
        src_ext     = {1'b0, src};
        seen_ext    = 33'(seen_c);
        more        = (n_reg < RES_CNT_W'(MAX_RES)) && (done_reg < total_c)
                      && (cmd_reg.block_end || ((src_ext + 33'd10) <= seen_ext));
        need_b      = (src_ext + 33'd1) < seen_ext;
        out_free    = !out_valid_reg || pop;
        flt_done    = v2_reg && last2_reg;

        // Window edges: before the block reads the first sample, past it the last.
        pos_neg  = pos_reg[POS_W-1];
        pos_past = !pos_neg && ($unsigned(pos_reg) >= POS_W'(seen_c));
        rd_addr  = pos_past ? last_slot_c : addr_reg;
        addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;

        op_smp  = first1_reg ? cmd_reg.first_sample : $signed(ram_rdata);
        diff    = {b_reg[15], b_reg} - {a_reg[15], a_reg};
        mul_a   = (state_reg == B_INTERP) ? MUL_W'(diff) : MUL_W'(op_smp);
        mul_b   = (state_reg == B_INTERP) ? $signed({2'b00, frac})
                                          : MUL_W'(tap_coef(t1_reg));
        product = mul_a * mul_b;

        acc_rnd = acc_reg + ACC_W'(ROUND_HALF);
        acc_q   = acc_rnd >>> 15;
        flt_val = sat16(acc_q);

        // a*(1-f) + b*f == a + (b-a)*f, floored.
        mix     = MIX_W'(a_reg) + $signed(prod_reg[ACC_W-1:16]);
        mix_val = sat16(ACC_W'(mix));

        frac_sum  = {1'b0, frac} + {1'b0, STEP_FRAC};
        smod_sum  = {1'b0, smod_reg} + (frac_sum[16] ? (AW + 1)'(2) : (AW + 1)'(1));
        smod_next = (smod_sum >= DEPTH_EXT) ? AW'(smod_sum - DEPTH_EXT) : smod_sum[AW-1:0];

        pos_a = $signed({2'b00, src}) - $signed(POS_W'(TAP_CENTER));
        pos_b = $signed({2'b00, src}) - $signed(POS_W'(TAP_CENTER - 1));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    state_next = more ? B_FILT : B_IDLE;
                end
            end
            B_FILT:
            begin
                if (flt_done)
                begin
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                state_next = (!pass_reg && need_b) ? B_FILT : B_INTERP;
            end
            B_INTERP:
            begin
                state_next = B_MIX;
            end
            B_MIX:
            begin
                state_next = B_CHECK;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer strobes.
    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        init_a    = 1'b0;
        init_b    = 1'b0;
        ld_a      = 1'b0;
        ld_b      = 1'b0;
        ld_b_dup  = 1'b0;
        hold_ld   = 1'b0;
        blk_clr   = 1'b0;
        flt_issue = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_CHECK:
            begin
                emit = hold_valid_reg && out_free;
                if (!hold_valid_reg || out_free)
                begin
                    init_a  = more;
                    blk_clr = !more && cmd_reg.block_end;
                end
            end
            B_FILT:
            begin
                flt_issue = (iss_reg < TAP_IDX_W'(NUM_TAPS));
            end
            B_ROUND:
            begin
                ld_a     = !pass_reg;
                init_b   = !pass_reg && need_b;
                ld_b_dup = !pass_reg && !need_b;
                ld_b     = pass_reg;
            end
            B_INTERP:
            begin
                q_pop = 1'b0;
            end
            B_MIX:
            begin
                hold_ld = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_dout;
        end
        if (init_a || init_b)
        begin
            pos_reg  <= init_a ? pos_a : pos_b;
            addr_reg <= init_a ? slot_back(smod_reg, 4'(TAP_CENTER))
                               : slot_back(smod_reg, 4'(TAP_CENTER - 1));
        end
        else if (flt_issue)
        begin
            pos_reg  <= pos_reg + POS_W'(1);
            addr_reg <= addr_inc;
        end
        t1_reg     <= iss_reg;
        first1_reg <= pos_neg;
        last2_reg  <= (t1_reg == TAP_IDX_W'(NUM_TAPS - 1));
        if (v1_reg || (state_reg == B_INTERP))
        begin
            prod_reg <= product;
        end
        if (init_a || init_b)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (ld_a)
        begin
            a_reg <= flt_val;
        end
        if (ld_b || ld_b_dup)
        begin
            b_reg <= flt_val;
        end
        if (hold_ld)
        begin
            hold_reg <= mix_val;
        end
        if (emit)
        begin
            out_sample_reg <= hold_reg;
            out_last_reg   <= !more;
            out_done_reg   <= !more && cmd_reg.block_end;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            done_reg       <= '0;
            phase_reg      <= '0;
            smod_reg       <= '0;
            n_reg          <= '0;
            pass_reg       <= 1'b0;
            iss_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                n_reg <= '0;
            end
            if (init_a || init_b)
            begin
                iss_reg  <= '0;
                pass_reg <= init_b;
            end
            else if (flt_issue)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            v1_reg <= flt_issue;
            v2_reg <= v1_reg;
            if (hold_ld)
            begin
                hold_valid_reg <= 1'b1;
                done_reg       <= done_reg + 1'b1;
                phase_reg      <= phase_reg + 48'(PHASE_INC);
                smod_reg       <= smod_next;
                n_reg          <= n_reg + 1'b1;
            end
            else if (emit)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (blk_clr)
            begin
                done_reg  <= '0;
                phase_reg <= '0;
                smod_reg  <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty      = !out_valid_reg;
    assign sample_out = out_sample_reg;
    assign run_last   = out_valid_reg && out_last_reg;
    assign block_done = out_valid_reg && out_done_reg;

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_CNT_W'(MAX_RES))
        else $error("more results than allowed for one beat");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("block_done without run_last");

    a_hold_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(hold_valid_reg) |-> $past(state_reg == B_CHECK))
        else $error("pending result dropped outside check");

    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> state_reg == B_FILT)
        else $error("MAC pipeline active outside filter pass");

endmodule

[rtl/fir_linear_resampler_22k_to_16k.sv]
// 22050 Hz to 16000 Hz resampler: 17-tap Q15 low-pass at two neighboring
// input positions, then linear interpolation on the 16-bit phase fraction.
//
// Input channel: push/full. A beat carries sample_in and block_end; block_end
// marks the last sample of a block and flushes the outputs still owed.
// Result channel: empty/pop. sample_out, run_last (last result of one input
// beat) and block_done (final output of the block) are valid while empty is low.
// Config channel: cfg_valid/cfg_ready/cfg_data writes output_limit; cfg_ready
// is always high. Write it only while the block is idle.
//
// Each output: check, two filter passes on the shared 18x18 multiply-accumulate
// each followed by a round, interpolate, mix; a single filter pass and round
// when the upper position lies past the block. Up to ten outputs per beat.
// A beat holds the back end until all of its outputs are made.
// A two-entry command queue lets inputs be taken while the back end works.
// Reset: all block counters clear, output_limit returns to 16777215; history
// contents stay undefined until written.
// A stalled receiver holds one result in the output register and one pending;
// the back end then waits, and input beats back up into the command queue.
module fir_linear_resampler_22k_to_16k #(
    parameter int HISTORY_DEPTH = 32,
    parameter int COUNT_WIDTH   = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] sample_in,
    input  logic               block_end,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample_out,
    output logic               run_last,
    output logic               block_done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data
);
    import frs_pkg::*;

    // Front -> queue -> back.
    frs_cmd_t cmd_in;
    frs_cmd_t cmd_out;
    logic     cmd_push;
    logic     cmd_pop;
    logic     q_full;
    logic     q_empty;

    assign full = q_full;

    // Front: sample counting, output budget, ring slot, output limit.
    frs_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample_in (sample_in),
        .block_end (block_end),
        .q_full    (q_full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    frs_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (cmd_push),
        .q_din   (cmd_in),
        .q_full  (q_full),
        .q_pop   (cmd_pop),
        .q_dout  (cmd_out),
        .q_empty (q_empty)
    );

    // Back: history store, filter/interpolate sequencer, result register.
    frs_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_dout     (cmd_out),
        .q_pop      (cmd_pop),
        .empty      (empty),
        .pop        (pop),
        .sample_out (sample_out),
        .run_last   (run_last),
        .block_done (block_done)
    );

endmodule
